// ===== design/mfb_pkg.sv =====
// Shared types, codes, widths and the sigmoid table function of the MLP unit.
package mfb_pkg;

  // Operand and product widths of the shared multiplier
  localparam int A_W    = 34;
  localparam int B_W    = 18;
  localparam int PROD_W = A_W + B_W;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_LAYERS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE0      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE1      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE2      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE3      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 3'd5;

  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

  typedef enum logic [2:0] {
    OP_WR_W   = 3'd0,
    OP_WR_IN  = 3'd1,
    OP_WR_ERR = 3'd2,
    OP_FWD    = 3'd3,
    OP_BP     = 3'd4,
    OP_RD_W   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_FWD = 2'd0,
    KIND_RDW = 2'd1,
    KIND_BP  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_SET,
    ACC_ADD,
    ACC_SETW
  } acc_op_e;

  typedef enum logic [1:0] {
    RND_F,
    RND_2F,
    RND_UPD
  } rnd_e;

  typedef struct packed {
    logic    mul;
    acc_op_e acc_op;
    rnd_e    rnd;
  } alu_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RW_OUT,
    ST_F_RD,
    ST_F_MUL,
    ST_F_ACC,
    ST_F_SIG,
    ST_F_WR,
    ST_FO_RD,
    ST_FO_OUT,
    ST_B_RD,
    ST_B_M1,
    ST_B_M2,
    ST_B_ACC,
    ST_B_WR,
    ST_H_RD,
    ST_H_MUL,
    ST_H_ACC,
    ST_H_S,
    ST_H_M1,
    ST_H_M2,
    ST_H_ACC2,
    ST_H_WR,
    ST_U_RD0,
    ST_U_D,
    ST_U_DL,
    ST_U_RD,
    ST_U_MUL,
    ST_U_ACC,
    ST_U_WR,
    ST_B_OUT
  } state_e;

  // Long division by shift and subtract, for table construction only
  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r    = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid at the midpoint of bin i, Q32 series for exp
  function automatic logic [15:0] sig_entry(input int i, input int frac, input int depth);
    longint      num;
    longint      sum;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] s;
    logic [63:0] f;
    logic [63:0] term;
    int          n;
    num = (longint'(2 * i + 1) - longint'(depth)) * 64'sd65536;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    a   = udiv(mag << (32 - frac), 64'(2 * depth));
    e   = '0;
    if (a < (64'd32 << 32)) begin
      f    = {32'd0, a[31:0]};
      term = 64'd1 << 32;
      sum  = 64'sd1 <<< 32;
      n    = int'(a[63:32]);
      for (int k = 1; k <= 16; k++) begin
        term = udiv((term * f) >> 32, 64'(k));
        if ((k & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      e = 64'(sum);
      for (int k = 0; k < n; k++) begin
        e = (e * EXP_M1_Q32) >> 32;
      end
    end
    den = (64'd1 << 32) + e;
    if (num >= 0) s = udiv((64'd1 << (frac + 32)) + (den >> 1), den);
    else s = udiv((64'd1 << frac) * e + (den >> 1), den);
    return (s > 64'd32767) ? 16'd32767 : s[15:0];
  endfunction

endpackage

// ===== design/mfb_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module mfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds when idle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/mfb_alu.sv =====
// Shared multiply-accumulate unit with round-and-saturate output.
module mfb_alu #(
  parameter int FRAC_BITS   = 12,
  parameter int MAX_NEURONS = 16
) (
  input  logic                             clk_i,
  input  mfb_pkg::alu_cmd_t                cmd_i,
  input  logic signed [mfb_pkg::A_W-1:0]   a_i,
  input  logic signed [mfb_pkg::B_W-1:0]   b_i,
  input  logic signed [15:0]               wadd_i,
  output logic signed [mfb_pkg::A_W-1:0]   prod_lo_o,
  output logic signed [15:0]               res_o
);

  localparam int ACC_W   = mfb_pkg::PROD_W + $clog2(MAX_NEURONS + 2);
  localparam int S_F     = FRAC_BITS;
  localparam int S_2F    = 2 * FRAC_BITS;
  localparam int S_UPD   = 16 + FRAC_BITS;

  logic signed [mfb_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]           acc_d, acc_q;

  // Round to nearest (ties up), then saturate to 16 bits
  function automatic logic signed [15:0] rnd_sat(input logic signed [ACC_W-1:0] x,
                                                 input int s);
    logic signed [ACC_W:0] t;
    t = {x[ACC_W-1], x} + ((ACC_W + 1)'(1) << (s - 1));
    t = t >>> s;
    if (t > 32767) return 16'sh7FFF;
    if (t < -32768) return 16'sh8000;
    return t[15:0];
  endfunction

  assign prod_d = a_i * b_i;

  // Accumulator update
  always_comb begin
    case (cmd_i.acc_op)
      mfb_pkg::ACC_SET:  acc_d = ACC_W'(prod_q);
      mfb_pkg::ACC_ADD:  acc_d = acc_q + ACC_W'(prod_q);
      mfb_pkg::ACC_SETW: acc_d = ACC_W'(prod_q) + (ACC_W'(wadd_i) <<< S_UPD);
      default:           acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  // Select the scaling of the result
  always_comb begin
    case (cmd_i.rnd)
      mfb_pkg::RND_F:   res_o = rnd_sat(acc_q, S_F);
      mfb_pkg::RND_2F:  res_o = rnd_sat(acc_q, S_2F);
      default:          res_o = rnd_sat(acc_q, S_UPD);
    endcase
  end

  assign prod_lo_o = prod_q[mfb_pkg::A_W-1:0];

endmodule

// ===== design/mfb_sig.sv =====
// Sigmoid lookup table with registered output.
module mfb_sig #(
  parameter int FRAC_BITS = 12,
  parameter int DEPTH     = 256
) (
  input  logic               clk_i,
  input  logic signed [15:0] x_i,
  output logic [15:0]        y_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int PW = 16 + IW;

  logic [15:0]   tab [DEPTH];
  logic [15:0]   u;
  logic [PW-1:0] scaled;
  logic [IW-1:0] idx;
  logic [15:0]   y_q;

  // Build the table at elaboration
  for (genvar g = 0; g < DEPTH; g++) begin : g_tab
    localparam logic [15:0] V = mfb_pkg::sig_entry(g, FRAC_BITS, DEPTH);
    assign tab[g] = V;
  end

  // Map the signed input onto a bin
  assign u      = {~x_i[15], x_i[14:0]};
  assign scaled = PW'(u) * PW'(DEPTH);
  assign idx    = scaled[PW-1:16];

  always_ff @(posedge clk_i) begin
    y_q <= tab[idx];
  end

  assign y_o = y_q;

endmodule

// ===== design/mlp_forward_backprop_unit.sv =====
// Forward: per neuron, read, multiply, accumulate for bias and each input, then
// sigmoid and write; each emitted word is read, then output. Backprop: output
// deltas, hidden deltas over the next layer, then the update of each weight and
// bias; one multiplier serves all. A weight read returns its word registered.
// Reset clears the sequencer and the output register, and loads config defaults;
// the weight, activation, delta and error memories are undefined until written.
module mlp_forward_backprop_unit #(
  parameter int MAX_LAYERS          = 4,
  parameter int MAX_NEURONS         = 16,
  parameter int FRAC_BITS           = 12,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // cfg
  input  logic                            cfg_we_i,
  input  logic [mfb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]                     cfg_wdata_i,
  // input words
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  // layer[1:0], neuron[5:2], weight_index[10:6], value[26:11]
  input  logic [31:0]                     s_tdata_i,
  // op[2:0]
  input  logic [2:0]                      s_tuser_i,
  // result words
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // index[3:0], result_value[19:4]
  output logic [23:0]                     m_tdata_o,
  // kind[1:0]
  output logic [1:0]                      m_tuser_o,
  output logic                            m_tlast_o
);

  localparam int SLOTS   = MAX_NEURONS + 1;
  localparam int W_DEPTH = (MAX_LAYERS - 1) * MAX_NEURONS * SLOTS;
  localparam int A_DEPTH = MAX_LAYERS * MAX_NEURONS;
  localparam int WAW     = $clog2(W_DEPTH);
  localparam int AAW     = $clog2(A_DEPTH);
  localparam int EAW     = $clog2(MAX_NEURONS);
  localparam int NW      = $clog2(MAX_NEURONS + 1);
  localparam int NL_HI   = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
  localparam int AW      = mfb_pkg::A_W;
  localparam int BW      = mfb_pkg::B_W;
  localparam logic signed [BW-1:0] ONE_B = BW'(64'd1 << FRAC_BITS);

  // Config registers
  logic [2:0]  nl_q;
  logic [4:0]  size_q [4];
  logic [15:0] lr_q;

  mfb_pkg::state_e state_q, state_d;

  logic [1:0]    l_q, l_d;
  logic [NW-1:0] j_q, j_d, k_q, k_d;
  logic signed [15:0] s_q, s_d;
  logic signed [AW-1:0] d_q, d_d;
  logic [3:0]    rw_neuron_q, rw_neuron_d;
  logic          rw_ok_q, rw_ok_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_kind_q, out_kind_d;
  logic [3:0]    out_index_q, out_index_d;
  logic [15:0]   out_value_q, out_value_d;
  logic          out_last_q, out_last_d;
  logic          out_free;

  // Memory ports
  logic           w_we, w_re, a_we, a_re, d_we, d_re, e_we, e_re;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [AAW-1:0] a_waddr, a_raddr, d_waddr, d_raddr;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [15:0]    w_wdata, a_wdata, d_wdata, e_wdata;
  logic [15:0]    w_rdata, a_rdata, d_rdata, e_rdata;

  // Shared unit
  mfb_pkg::alu_cmd_t     alu_cmd;
  logic signed [AW-1:0]  alu_a, alu_prod_lo;
  logic signed [BW-1:0]  alu_b;
  logic signed [15:0]    alu_res;
  logic [15:0]           sig_y;

  // Input fields
  logic [1:0]   in_layer;
  logic [3:0]   in_neuron;
  logic [4:0]   in_wi;
  logic [15:0]  in_value;
  logic         s_fire, waddr_ok, nidx_ok;
  mfb_pkg::op_e in_op;

  logic [2:0]    nl_c;
  logic [1:0]    last_l;
  logic [NW-1:0] sz_l, sz_prev, sz_next, j_inc;
  logic          k_end, j_end, hk_end;

  function automatic logic [NW-1:0] lsize(input int l);
    logic [4:0] r;
    r = (l == 0) ? size_q[0] : (l == 1) ? size_q[1] : (l == 2) ? size_q[2] : size_q[3];
    if (r == 5'd0) return NW'(1);
    if (int'(r) > MAX_NEURONS) return NW'(MAX_NEURONS);
    return NW'(r);
  endfunction

  function automatic logic [WAW-1:0] widx(input int l, input int j, input int k);
    return WAW'(((l - 1) * MAX_NEURONS + j) * SLOTS + k);
  endfunction

  function automatic logic [AAW-1:0] aaddr(input int l, input int j);
    return AAW'(l * MAX_NEURONS + j);
  endfunction

  assign in_layer  = s_tdata_i[1:0];
  assign in_neuron = s_tdata_i[5:2];
  assign in_wi     = s_tdata_i[10:6];
  assign in_value  = s_tdata_i[26:11];
  assign in_op     = mfb_pkg::op_e'(s_tuser_i);
  assign s_tready_o = (state_q == mfb_pkg::ST_IDLE);
  assign s_fire    = s_tvalid_i && s_tready_o;
  assign nidx_ok   = int'(in_neuron) < MAX_NEURONS;
  assign waddr_ok  = (in_layer != 2'd0) && (int'(in_layer) < MAX_LAYERS) && nidx_ok &&
                     (int'(in_wi) <= MAX_NEURONS);

  assign nl_c   = (nl_q < 3'd3) ? 3'd3 : ((int'(nl_q) > NL_HI) ? 3'(NL_HI) : nl_q);
  assign last_l = 2'(nl_c - 3'd1);

  assign sz_l    = lsize(int'(l_q));
  assign sz_prev = lsize(int'(l_q) - 1);
  assign sz_next = lsize(int'(l_q) + 1);
  assign j_inc   = j_q + NW'(1);
  assign k_end   = (k_q == sz_prev);
  assign j_end   = (j_inc == sz_l);
  assign hk_end  = ((k_q + NW'(1)) == sz_next);
  assign out_free = !out_valid_q || m_tready_i;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nl_q      <= 3'd4;
      size_q[0] <= 5'd10;
      size_q[1] <= 5'd14;
      size_q[2] <= 5'd13;
      size_q[3] <= 5'd10;
      lr_q      <= 16'd655;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mfb_pkg::CFG_NUM_LAYERS: nl_q      <= cfg_wdata_i[2:0];
        mfb_pkg::CFG_SIZE0:      size_q[0] <= cfg_wdata_i[4:0];
        mfb_pkg::CFG_SIZE1:      size_q[1] <= cfg_wdata_i[4:0];
        mfb_pkg::CFG_SIZE2:      size_q[2] <= cfg_wdata_i[4:0];
        mfb_pkg::CFG_SIZE3:      size_q[3] <= cfg_wdata_i[4:0];
        mfb_pkg::CFG_LEARN_RATE: lr_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mfb_pkg::ST_IDLE: begin
        if (s_fire) begin
          case (in_op)
            mfb_pkg::OP_FWD:  state_d = mfb_pkg::ST_F_RD;
            mfb_pkg::OP_BP:   state_d = mfb_pkg::ST_B_RD;
            mfb_pkg::OP_RD_W: state_d = mfb_pkg::ST_RW_OUT;
            default:          state_d = mfb_pkg::ST_IDLE;
          endcase
        end
      end
      mfb_pkg::ST_RW_OUT: if (out_free) state_d = mfb_pkg::ST_IDLE;
      mfb_pkg::ST_F_RD:   state_d = mfb_pkg::ST_F_MUL;
      mfb_pkg::ST_F_MUL:  state_d = mfb_pkg::ST_F_ACC;
      mfb_pkg::ST_F_ACC:  state_d = k_end ? mfb_pkg::ST_F_SIG : mfb_pkg::ST_F_RD;
      mfb_pkg::ST_F_SIG:  state_d = mfb_pkg::ST_F_WR;
      mfb_pkg::ST_F_WR: begin
        if (j_end && (l_q == last_l)) state_d = mfb_pkg::ST_FO_RD;
        else state_d = mfb_pkg::ST_F_RD;
      end
      mfb_pkg::ST_FO_RD:  state_d = mfb_pkg::ST_FO_OUT;
      mfb_pkg::ST_FO_OUT: begin
        if (out_free) state_d = j_end ? mfb_pkg::ST_IDLE : mfb_pkg::ST_FO_RD;
      end
      mfb_pkg::ST_B_RD:   state_d = mfb_pkg::ST_B_M1;
      mfb_pkg::ST_B_M1:   state_d = mfb_pkg::ST_B_M2;
      mfb_pkg::ST_B_M2:   state_d = mfb_pkg::ST_B_ACC;
      mfb_pkg::ST_B_ACC:  state_d = mfb_pkg::ST_B_WR;
      mfb_pkg::ST_B_WR:   state_d = j_end ? mfb_pkg::ST_H_RD : mfb_pkg::ST_B_RD;
      mfb_pkg::ST_H_RD:   state_d = mfb_pkg::ST_H_MUL;
      mfb_pkg::ST_H_MUL:  state_d = mfb_pkg::ST_H_ACC;
      mfb_pkg::ST_H_ACC:  state_d = hk_end ? mfb_pkg::ST_H_S : mfb_pkg::ST_H_RD;
      mfb_pkg::ST_H_S:    state_d = mfb_pkg::ST_H_M1;
      mfb_pkg::ST_H_M1:   state_d = mfb_pkg::ST_H_M2;
      mfb_pkg::ST_H_M2:   state_d = mfb_pkg::ST_H_ACC2;
      mfb_pkg::ST_H_ACC2: state_d = mfb_pkg::ST_H_WR;
      mfb_pkg::ST_H_WR: begin
        if (j_end && (l_q == 2'd1)) state_d = mfb_pkg::ST_U_RD0;
        else state_d = mfb_pkg::ST_H_RD;
      end
      mfb_pkg::ST_U_RD0:  state_d = mfb_pkg::ST_U_D;
      mfb_pkg::ST_U_D:    state_d = mfb_pkg::ST_U_DL;
      mfb_pkg::ST_U_DL:   state_d = mfb_pkg::ST_U_RD;
      mfb_pkg::ST_U_RD:   state_d = mfb_pkg::ST_U_MUL;
      mfb_pkg::ST_U_MUL:  state_d = mfb_pkg::ST_U_ACC;
      mfb_pkg::ST_U_ACC:  state_d = mfb_pkg::ST_U_WR;
      mfb_pkg::ST_U_WR: begin
        if (!k_end) state_d = mfb_pkg::ST_U_RD;
        else if (j_end && (l_q == last_l)) state_d = mfb_pkg::ST_B_OUT;
        else state_d = mfb_pkg::ST_U_RD0;
      end
      mfb_pkg::ST_B_OUT:  if (out_free) state_d = mfb_pkg::ST_IDLE;
      default:            state_d = mfb_pkg::ST_IDLE;
    endcase
  end

  // Outputs: memory ports, shared unit, counters, result register
  always_comb begin
    w_we = 1'b0; w_re = 1'b0; w_waddr = '0; w_raddr = '0; w_wdata = '0;
    a_we = 1'b0; a_re = 1'b0; a_waddr = '0; a_raddr = '0; a_wdata = '0;
    d_we = 1'b0; d_re = 1'b0; d_waddr = '0; d_raddr = '0; d_wdata = '0;
    e_we = 1'b0; e_re = 1'b0; e_waddr = '0; e_raddr = '0; e_wdata = '0;
    alu_cmd = '{mul: 1'b0, acc_op: mfb_pkg::ACC_HOLD, rnd: mfb_pkg::RND_F};
    alu_a = '0;
    alu_b = '0;
    l_d = l_q; j_d = j_q; k_d = k_q; s_d = s_q; d_d = d_q;
    rw_neuron_d = rw_neuron_q; rw_ok_d = rw_ok_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_kind_d  = out_kind_q;
    out_index_d = out_index_q;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    case (state_q)
      mfb_pkg::ST_IDLE: begin
        l_d = 2'd1; j_d = '0; k_d = '0;
        if (s_fire) begin
          case (in_op)
            mfb_pkg::OP_WR_W: begin
              w_we    = waddr_ok;
              w_waddr = widx(int'(in_layer), int'(in_neuron), int'(in_wi));
              w_wdata = in_value;
            end
            mfb_pkg::OP_WR_IN: begin
              a_we    = nidx_ok;
              a_waddr = AAW'(in_neuron);
              a_wdata = in_value;
            end
            mfb_pkg::OP_WR_ERR: begin
              e_we    = nidx_ok;
              e_waddr = EAW'(in_neuron);
              e_wdata = in_value;
            end
            mfb_pkg::OP_BP: l_d = last_l;
            mfb_pkg::OP_RD_W: begin
              w_re        = 1'b1;
              w_raddr     = waddr_ok ? widx(int'(in_layer), int'(in_neuron), int'(in_wi)) : '0;
              rw_neuron_d = in_neuron;
              rw_ok_d     = waddr_ok;
            end
            default: ;
          endcase
        end
      end
      mfb_pkg::ST_RW_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = mfb_pkg::KIND_RDW;
          out_index_d = rw_neuron_q;
          out_value_d = rw_ok_q ? w_rdata : 16'd0;
          out_last_d  = 1'b1;
        end
      end
      // Forward: biased weighted sum, sigmoid, store
      mfb_pkg::ST_F_RD: begin
        w_re    = 1'b1;
        w_raddr = widx(int'(l_q), int'(j_q), int'(k_q));
        a_re    = (k_q != '0);
        a_raddr = aaddr(int'(l_q) - 1, int'(k_q) - 1);
      end
      mfb_pkg::ST_F_MUL: begin
        alu_cmd.mul = 1'b1;
        alu_a = AW'($signed(w_rdata));
        alu_b = (k_q == '0) ? ONE_B : BW'($signed(a_rdata));
      end
      mfb_pkg::ST_F_ACC: begin
        alu_cmd.acc_op = (k_q == '0) ? mfb_pkg::ACC_SET : mfb_pkg::ACC_ADD;
        if (!k_end) k_d = k_q + NW'(1);
      end
      mfb_pkg::ST_F_SIG: alu_cmd.rnd = mfb_pkg::RND_F;
      mfb_pkg::ST_F_WR: begin
        a_we    = 1'b1;
        a_waddr = aaddr(int'(l_q), int'(j_q));
        a_wdata = sig_y;
        k_d     = '0;
        if (j_end) begin
          j_d = '0;
          if (l_q != last_l) l_d = l_q + 2'd1;
        end else begin
          j_d = j_inc;
        end
      end
      mfb_pkg::ST_FO_RD: begin
        a_re    = 1'b1;
        a_raddr = aaddr(int'(l_q), int'(j_q));
      end
      mfb_pkg::ST_FO_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = mfb_pkg::KIND_FWD;
          out_index_d = 4'(j_q);
          out_value_d = a_rdata;
          out_last_d  = j_end;
          j_d         = j_inc;
        end
      end
      // Output-layer deltas
      mfb_pkg::ST_B_RD: begin
        a_re    = 1'b1;
        a_raddr = aaddr(int'(l_q), int'(j_q));
        e_re    = 1'b1;
        e_raddr = EAW'(j_q);
      end
      mfb_pkg::ST_B_M1, mfb_pkg::ST_H_M1: begin
        alu_cmd.mul = 1'b1;
        alu_a = AW'($signed(a_rdata));
        alu_b = ONE_B - BW'($signed(a_rdata));
      end
      mfb_pkg::ST_B_M2: begin
        alu_cmd.mul = 1'b1;
        alu_a = alu_prod_lo;
        alu_b = BW'($signed(e_rdata));
      end
      mfb_pkg::ST_B_ACC, mfb_pkg::ST_H_ACC2: alu_cmd.acc_op = mfb_pkg::ACC_SET;
      mfb_pkg::ST_B_WR: begin
        alu_cmd.rnd = mfb_pkg::RND_2F;
        d_we    = 1'b1;
        d_waddr = aaddr(int'(l_q), int'(j_q));
        d_wdata = alu_res;
        k_d     = '0;
        if (j_end) begin
          j_d = '0;
          l_d = l_q - 2'd1;
        end else begin
          j_d = j_inc;
        end
      end
      // Hidden-layer deltas from the weights before update
      mfb_pkg::ST_H_RD: begin
        w_re    = 1'b1;
        w_raddr = widx(int'(l_q) + 1, int'(k_q), int'(j_q) + 1);
        d_re    = 1'b1;
        d_raddr = aaddr(int'(l_q) + 1, int'(k_q));
      end
      mfb_pkg::ST_H_MUL: begin
        alu_cmd.mul = 1'b1;
        alu_a = AW'($signed(w_rdata));
        alu_b = BW'($signed(d_rdata));
      end
      mfb_pkg::ST_H_ACC: begin
        alu_cmd.acc_op = (k_q == '0) ? mfb_pkg::ACC_SET : mfb_pkg::ACC_ADD;
        if (!hk_end) k_d = k_q + NW'(1);
      end
      mfb_pkg::ST_H_S: begin
        alu_cmd.rnd = mfb_pkg::RND_F;
        s_d     = alu_res;
        a_re    = 1'b1;
        a_raddr = aaddr(int'(l_q), int'(j_q));
      end
      mfb_pkg::ST_H_M2: begin
        alu_cmd.mul = 1'b1;
        alu_a = alu_prod_lo;
        alu_b = BW'(s_q);
      end
      mfb_pkg::ST_H_WR: begin
        alu_cmd.rnd = mfb_pkg::RND_2F;
        d_we    = 1'b1;
        d_waddr = aaddr(int'(l_q), int'(j_q));
        d_wdata = alu_res;
        k_d     = '0;
        if (j_end) begin
          j_d = '0;
          if (l_q != 2'd1) l_d = l_q - 2'd1;
        end else begin
          j_d = j_inc;
        end
      end
      // Weight update
      mfb_pkg::ST_U_RD0: begin
        d_re    = 1'b1;
        d_raddr = aaddr(int'(l_q), int'(j_q));
      end
      mfb_pkg::ST_U_D: begin
        alu_cmd.mul = 1'b1;
        alu_a = AW'($signed(d_rdata));
        alu_b = BW'(lr_q);
      end
      mfb_pkg::ST_U_DL: d_d = alu_prod_lo;
      mfb_pkg::ST_U_RD: begin
        w_re    = 1'b1;
        w_raddr = widx(int'(l_q), int'(j_q), int'(k_q));
        a_re    = (k_q != '0);
        a_raddr = aaddr(int'(l_q) - 1, int'(k_q) - 1);
      end
      mfb_pkg::ST_U_MUL: begin
        alu_cmd.mul = 1'b1;
        alu_a = d_q;
        alu_b = (k_q == '0) ? ONE_B : BW'($signed(a_rdata));
      end
      mfb_pkg::ST_U_ACC: alu_cmd.acc_op = mfb_pkg::ACC_SETW;
      mfb_pkg::ST_U_WR: begin
        alu_cmd.rnd = mfb_pkg::RND_UPD;
        w_we    = 1'b1;
        w_waddr = widx(int'(l_q), int'(j_q), int'(k_q));
        w_wdata = alu_res;
        if (k_end) begin
          k_d = '0;
          if (j_end) begin
            j_d = '0;
            l_d = l_q + 2'd1;
          end else begin
            j_d = j_inc;
          end
        end else begin
          k_d = k_q + NW'(1);
        end
      end
      mfb_pkg::ST_B_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = mfb_pkg::KIND_BP;
          out_index_d = 4'd0;
          out_value_d = 16'd0;
          out_last_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mfb_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      l_q         <= 2'd1;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      l_q         <= l_d;
      j_q         <= j_d;
      k_q         <= k_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    d_q         <= d_d;
    rw_neuron_q <= rw_neuron_d;
    rw_ok_q     <= rw_ok_d;
    out_kind_q  <= out_kind_d;
    out_index_q <= out_index_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'd0, out_value_q, out_index_q};
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;

  mfb_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_weight_ram (
    .clk_i(clk_i), .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .re_i(w_re), .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  mfb_ram #(.WIDTH(16), .DEPTH(A_DEPTH)) u_act_ram (
    .clk_i(clk_i), .we_i(a_we), .waddr_i(a_waddr), .wdata_i(a_wdata),
    .re_i(a_re), .raddr_i(a_raddr), .rdata_o(a_rdata)
  );

  mfb_ram #(.WIDTH(16), .DEPTH(A_DEPTH)) u_delta_ram (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .re_i(d_re), .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  mfb_ram #(.WIDTH(16), .DEPTH(MAX_NEURONS)) u_err_ram (
    .clk_i(clk_i), .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .re_i(e_re), .raddr_i(e_raddr), .rdata_o(e_rdata)
  );

  mfb_alu #(.FRAC_BITS(FRAC_BITS), .MAX_NEURONS(MAX_NEURONS)) u_alu (
    .clk_i(clk_i), .cmd_i(alu_cmd), .a_i(alu_a), .b_i(alu_b), .wadd_i($signed(w_rdata)),
    .prod_lo_o(alu_prod_lo), .res_o(alu_res)
  );

  mfb_sig #(.FRAC_BITS(FRAC_BITS), .DEPTH(SIGMOID_TABLE_DEPTH)) u_sig (
    .clk_i(clk_i), .x_i(alu_res), .y_o(sig_y)
  );

endmodule
